@@ rtl/mctpt_pkg.sv @@
// Package with the shared types, constants and register indexes of the turbo pulse timer.
`timescale 1ns / 1ps

package mctpt_pkg;

    localparam int CHANNELS   = 16;
    localparam int MAX_CHAN   = 16;
    localparam int TIME_W     = 32;
    localparam int DUR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = TIME_W + 2 * MAX_CHAN;
    localparam int OUT_BITS   = 2 + MAX_CHAN;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] GRACE_MS = TIME_W'(150);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MASK   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_DELAY = 4'b0010,
        PH_ON    = 4'b0100,
        PH_OFF   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [DUR_W-1:0] start_delay_ms;
        logic [DUR_W-1:0] pulse_on_ms;
        logic [DUR_W-1:0] pulse_off_ms;
    } timing_cfg_t;

    typedef struct packed {
        logic held;
        logic active;
        logic pulse;
    } chan_status_t;

endpackage

@@ rtl/mctpt_channel.sv @@
// One timer channel: release grace, phase sequencer and its state registers.
`timescale 1ns / 1ps

module mctpt_channel (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                update,
    input  logic                                enabled,
    input  mctpt_pkg::timing_cfg_t              cfg,
    input  logic [mctpt_pkg::TIME_W-1:0]        now_ms,
    input  logic                                key_down,
    input  logic                                key_hit,
    output mctpt_pkg::chan_status_t             status
);

    mctpt_pkg::phase_t               phase_reg, phase_next;
    logic [mctpt_pkg::TIME_W-1:0]    phase_start_reg, phase_start_next;
    logic [mctpt_pkg::TIME_W-1:0]    release_stamp_reg, release_stamp_next;
    logic                            release_seen_reg, release_seen_next;
    logic                            was_down_reg;

    logic                            released;
    logic                            in_grace;
    logic                            held_now;
    logic [mctpt_pkg::TIME_W-1:0]    elapsed;
    logic [mctpt_pkg::TIME_W-1:0]    since_release;

    always_comb begin
        released           = !key_down && was_down_reg;
        release_seen_next  = release_seen_reg || released;
        release_stamp_next = released ? now_ms : release_stamp_reg;
        since_release      = now_ms - release_stamp_next;
        in_grace           = !key_down && release_seen_next && (since_release < mctpt_pkg::GRACE_MS);
        held_now           = key_down || key_hit || in_grace;
        elapsed            = now_ms - phase_start_reg;

        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        if (!held_now) begin
            phase_next = mctpt_pkg::PH_IDLE;
        end else begin
            unique case (phase_reg)
                mctpt_pkg::PH_IDLE: begin
                    phase_next       = (cfg.start_delay_ms != '0) ? mctpt_pkg::PH_DELAY
                                                                  : mctpt_pkg::PH_ON;
                    phase_start_next = now_ms;
                end
                mctpt_pkg::PH_DELAY: begin
                    if (elapsed >= {{(mctpt_pkg::TIME_W-mctpt_pkg::DUR_W){1'b0}},
                                    cfg.start_delay_ms}) begin
                        phase_next       = mctpt_pkg::PH_ON;
                        phase_start_next = now_ms;
                    end
                end
                mctpt_pkg::PH_ON: begin
                    if (elapsed >= {{(mctpt_pkg::TIME_W-mctpt_pkg::DUR_W){1'b0}},
                                    cfg.pulse_on_ms}) begin
                        phase_next       = mctpt_pkg::PH_OFF;
                        phase_start_next = now_ms;
                    end
                end
                mctpt_pkg::PH_OFF: begin
                    if (elapsed >= {{(mctpt_pkg::TIME_W-mctpt_pkg::DUR_W){1'b0}},
                                    cfg.pulse_off_ms}) begin
                        phase_next       = mctpt_pkg::PH_ON;
                        phase_start_next = now_ms;
                    end
                end
                default: begin
                    phase_next = mctpt_pkg::PH_IDLE;
                end
            endcase
        end

        // A disabled channel adds nothing to the result.
        status.held   = enabled && held_now;
        status.active = enabled && (phase_next != mctpt_pkg::PH_IDLE);
        status.pulse  = enabled && (phase_next == mctpt_pkg::PH_ON);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= mctpt_pkg::PH_IDLE;
            phase_start_reg   <= '0;
            release_stamp_reg <= '0;
            release_seen_reg  <= 1'b0;
            was_down_reg      <= 1'b0;
        end else if (update && enabled) begin
            phase_reg         <= phase_next;
            phase_start_reg   <= phase_start_next;
            release_stamp_reg <= release_stamp_next;
            release_seen_reg  <= release_seen_next;
            was_down_reg      <= key_down;
        end
    end

endmodule

@@ rtl/multi_channel_turbo_pulse_timer.sv @@
// Top level of the multi-channel turbo pulse timer: input register, channels, result register.
//
//   channel   direction  tdata fields (low bit up)                     tuser  tlast
//   s_        in         now_ms[31:0] key_down[47:32] key_hit[63:48]   -      -
//   m_        out        any_active[0] any_pulse[1] held_mask[17:2]    -      -
//   cfg_      in         write enable, index, 16-bit data              -      -
//
// One poll per cycle sustained while m_tready stays high; a poll's result is presented after it has
// passed the input register and the result register. The poll waits in the input register while
// the channel logic computes the result, which is then loaded into the result register.
// All channels update in parallel from the registered poll, so the next poll may follow at once.
// A stalled result holds the result register and then the input register; s_tready drops
// only when both are full. Reset is synchronous and clears all channel state.
`timescale 1ns / 1ps

module multi_channel_turbo_pulse_timer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // now_ms[31:0], key_down[47:32], key_hit[63:48]
    input  logic [mctpt_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // any_active[0], any_pulse[1], held_mask[17:2], zero padding above
    output logic [mctpt_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [mctpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mctpt_pkg::DUR_W-1:0]           cfg_wdata
);

    mctpt_pkg::timing_cfg_t             timing_reg;
    logic [mctpt_pkg::MAX_CHAN-1:0]     loop_mask_reg;

    logic                               in_valid_reg;
    logic [mctpt_pkg::IN_DATA_W-1:0]    in_data_reg;
    logic                               out_valid_reg;
    logic [mctpt_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                               advance;

    logic [mctpt_pkg::TIME_W-1:0]       now_ms;
    logic [mctpt_pkg::MAX_CHAN-1:0]     key_down;
    logic [mctpt_pkg::MAX_CHAN-1:0]     key_hit;
    logic [mctpt_pkg::MAX_CHAN-1:0]     held_vec;
    logic [mctpt_pkg::MAX_CHAN-1:0]     active_vec;
    logic [mctpt_pkg::MAX_CHAN-1:0]     pulse_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.start_delay_ms <= '0;
            timing_reg.pulse_on_ms    <= mctpt_pkg::DUR_W'(50);
            timing_reg.pulse_off_ms   <= mctpt_pkg::DUR_W'(50);
            loop_mask_reg             <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mctpt_pkg::REG_START_DELAY: timing_reg.start_delay_ms <= cfg_wdata;
                mctpt_pkg::REG_PULSE_ON:    timing_reg.pulse_on_ms    <= cfg_wdata;
                mctpt_pkg::REG_PULSE_OFF:   timing_reg.pulse_off_ms   <= cfg_wdata;
                mctpt_pkg::REG_LOOP_MASK:   loop_mask_reg             <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The registered poll moves on whenever the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    assign now_ms   = in_data_reg[mctpt_pkg::TIME_W-1:0];
    assign key_down = in_data_reg[mctpt_pkg::TIME_W +: mctpt_pkg::MAX_CHAN];
    assign key_hit  = in_data_reg[mctpt_pkg::TIME_W + mctpt_pkg::MAX_CHAN +: mctpt_pkg::MAX_CHAN];

    for (genvar i = 0; i < mctpt_pkg::MAX_CHAN; i++) begin : g_chan
        if (i < mctpt_pkg::CHANNELS) begin : g_used
            mctpt_pkg::chan_status_t status;

            mctpt_channel u_channel (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .update   (advance),
                .enabled  (loop_mask_reg[i]),
                .cfg      (timing_reg),
                .now_ms   (now_ms),
                .key_down (key_down[i]),
                .key_hit  (key_hit[i]),
                .status   (status)
            );

            assign held_vec[i]   = status.held;
            assign active_vec[i] = status.active;
            assign pulse_vec[i]  = status.pulse;
        end else begin : g_unused
            assign held_vec[i]   = 1'b0;
            assign active_vec[i] = 1'b0;
            assign pulse_vec[i]  = 1'b0;
        end
    end

    always_comb begin
        out_data_next    = '0;
        out_data_next[0] = |active_vec;
        out_data_next[1] = |pulse_vec;
        out_data_next[2 +: mctpt_pkg::MAX_CHAN] = held_vec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/mctpt_checker.sv @@
// Port-level checker for the turbo pulse timer, bound to the top level.
`timescale 1ns / 1ps

module mctpt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [mctpt_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready
);

    // No result can be pending in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A channel in pulse-on is never idle.
    a_pulse_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("pulse reported without an active channel");

    // An enabled channel is active exactly when it counts as held.
    a_active_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2 +: mctpt_pkg::MAX_CHAN] != '0)))
        else $error("active flag disagrees with held mask");

    // A poll accepted while no result is pending always yields a result.
    a_poll_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("accepted poll produced no result");

endmodule

bind multi_channel_turbo_pulse_timer mctpt_checker u_mctpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
